>>> rtl/calendar_date_arithmetic_macros.svh
// Assertion macros for the calendar date arithmetic block.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef CALENDAR_DATE_ARITHMETIC_MACROS_SVH
`define CALENDAR_DATE_ARITHMETIC_MACROS_SVH

// same-cycle implication
`define CDA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CDA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cda_pkg.sv
// Shared types, codes and helper functions of the calendar date block.
// No dependencies; imported by every RTL module.
package cda_pkg;

    localparam int unsigned CDA_YEAR_MAX = 9999;

    localparam int OP_W      = 2;
    localparam int IN_YEAR_W = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int OFF_W     = 21;
    localparam int ORD_W     = 2;
    localparam int CNT_W     = 22;

    localparam int YEAR_W    = 18;
    localparam int SERIAL_W  = 27;
    localparam int YS_W      = 26;
    localparam int PC_W      = 6;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 48;

    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 2'd1;
    localparam logic [OP_W-1:0] OP_CMP  = 2'd2;
    localparam logic [OP_W-1:0] OP_DIFF = 2'd3;

    localparam logic [ORD_W-1:0] ORD_EQUAL   = 2'd0;
    localparam logic [ORD_W-1:0] ORD_LATER   = 2'd1;
    localparam logic [ORD_W-1:0] ORD_EARLIER = 2'd2;

    localparam logic [MONTH_W-1:0] MONTHS = 4'd12;
    localparam logic [CNT_W-1:0]   CNT_MAX = '1;

    // x/25 = (x * RECIP25) >> RECIP25_SHIFT, exact for the year range used
    localparam int RECIP25_W     = 13;
    localparam logic [RECIP25_W-1:0] RECIP25 = 13'd5243;
    localparam int RECIP25_SHIFT = 17;

    // year estimate from day serial: s * 2^32 / 365.2425
    localparam int EST_IN_W      = 25;
    localparam int RECIP_Y_W     = 24;
    localparam logic [RECIP_Y_W-1:0] RECIP_YEAR = 24'd11759221;
    localparam int RECIP_Y_SHIFT = 32;

    localparam logic [3:0] A_NOP    = 4'd0;
    localparam logic [3:0] A_LDDAY  = 4'd1;
    localparam logic [3:0] A_ADDYS  = 4'd2;
    localparam logic [3:0] A_SUBYS  = 4'd3;
    localparam logic [3:0] A_ADDML  = 4'd4;
    localparam logic [3:0] A_SUBML  = 4'd5;
    localparam logic [3:0] A_ADDOFF = 4'd6;
    localparam logic [3:0] A_SUBT   = 4'd7;
    localparam logic [3:0] A_ABS    = 4'd8;

    localparam logic [2:0] Y_NOP    = 3'd0;
    localparam logic [2:0] Y_LDSEL  = 3'd1;
    localparam logic [2:0] Y_LDEST  = 3'd2;
    localparam logic [2:0] Y_INC    = 3'd3;
    localparam logic [2:0] Y_DEC    = 3'd4;

    localparam logic [1:0] K_NOP    = 2'd0;
    localparam logic [1:0] K_ONE    = 2'd1;
    localparam logic [1:0] K_INC    = 2'd2;

    localparam logic [1:0] E_NOP    = 2'd0;
    localparam logic [1:0] E_CHKY   = 2'd1;
    localparam logic [1:0] E_CHKT   = 2'd2;

    localparam logic [3:0] C_NEVER    = 4'd0;
    localparam logic [3:0] C_ALWAYS   = 4'd1;
    localparam logic [3:0] C_NO_REQ   = 4'd2;
    localparam logic [3:0] C_OUT_BUSY = 4'd3;
    localparam logic [3:0] C_IS_CMP   = 4'd4;
    localparam logic [3:0] C_IS_DIFF  = 4'd5;
    localparam logic [3:0] C_ERR      = 4'd6;
    localparam logic [3:0] C_MK_GE_M  = 4'd7;
    localparam logic [3:0] C_L1_EXIT  = 4'd8;
    localparam logic [3:0] C_YS_LE_S  = 4'd9;
    localparam logic [3:0] C_MDONE    = 4'd10;

    typedef struct packed {
        logic [3:0]      acc_op;
        logic [2:0]      year_op;
        logic [1:0]      mk_op;
        logic [1:0]      err_op;
        logic            sel;
        logic            save_tmp;
        logic            emit;
        logic [3:0]      cond;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic mk_ge_m;
        logic is_cmp;
        logic is_diff;
        logic err;
        logic l1_exit;
        logic ys_le_s;
        logic mdone;
    } t_flags;

    typedef struct packed {
        logic idle;
        logic emit;
    } t_seq_stat;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [IN_YEAR_W-1:0] y1;
        logic [MONTH_W-1:0]   m1;
        logic [DAY_W-1:0]     d1;
        logic [IN_YEAR_W-1:0] y2;
        logic [MONTH_W-1:0]   m2;
        logic [DAY_W-1:0]     d2;
        logic [OFF_W-1:0]     off;
    } t_req;

    typedef struct packed {
        logic                 err;
        logic [CNT_W-1:0]     count;
        logic [ORD_W-1:0]     order;
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [IN_YEAR_W-1:0] year;
    } t_res;

    function automatic logic [MONTH_W-1:0] cda_fix_month(input logic [MONTH_W-1:0] m);
        if (m == '0) begin
            return MONTH_W'(1);
        end
        if (m > MONTHS) begin
            return MONTHS;
        end
        return m;
    endfunction

    function automatic logic [DAY_W-1:0] cda_month_len(input logic leap,
                                                       input logic [MONTH_W-1:0] m);
        case (m)
            4'd2: begin
                return leap ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                return 5'd30;
            end
            default: begin
                return 5'd31;
            end
        endcase
    endfunction

    // days from 0001-01-01 to Jan 1 of year y; elaboration only
    function automatic int cda_year_start(input int y);
        int p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

endpackage

>>> rtl/cda_ys_unit.sv
// Three-stage pipeline: day serial of Jan 1 and leap flag of a year.
// Depends on cda_pkg.
module cda_ys_unit
    import cda_pkg::*;
(
    input  logic              i_clk,
    input  logic [YEAR_W-1:0] i_year,
    output logic [YS_W-1:0]   o_ys,
    output logic              o_leap
);

    localparam int Q4_W  = YEAR_W - 2;
    localparam int MUL_W = Q4_W + RECIP25_W;

    logic [YEAR_W-1:0] p;
    logic [Q4_W-1:0]   q4;
    logic [Q4_W-1:0]   y4;

    logic [Q4_W-1:0]   r1_q4;
    logic [YS_W-1:0]   r1_m365;
    logic [MUL_W-1:0]  r1_mul;
    logic              r1_ylo;
    logic [Q4_W-1:0]   r1_y4;
    logic [MUL_W-1:0]  r1_ymul;

    logic [Q4_W-1:0]   q100;
    logic [Q4_W-1:0]   yq;
    logic [Q4_W-1:0]   r2_q100;
    logic [YS_W-1:0]   r2_a;
    logic              r2_leap;

    logic [YS_W-1:0]   r3_ys;
    logic              r3_leap;

    assign p    = i_year - YEAR_W'(1);
    assign q4   = p[YEAR_W-1:2];
    assign y4   = i_year[YEAR_W-1:2];
    assign q100 = r1_mul[MUL_W-1:RECIP25_SHIFT] == '0 ? '0 :
                  Q4_W'(r1_mul[MUL_W-1:RECIP25_SHIFT]);
    assign yq   = Q4_W'(r1_ymul[MUL_W-1:RECIP25_SHIFT]);

    always_ff @(posedge i_clk) begin
        r1_q4   <= q4;
        r1_m365 <= YS_W'(p) * YS_W'(365);
        r1_mul  <= MUL_W'(q4) * MUL_W'(RECIP25);
        r1_ylo  <= (i_year[1:0] == 2'b00);
        r1_y4   <= y4;
        r1_ymul <= MUL_W'(y4) * MUL_W'(RECIP25);

        r2_q100 <= q100;
        r2_a    <= r1_m365 + YS_W'(r1_q4);
        r2_leap <= r1_ylo && ((Q4_W'(yq * Q4_W'(25)) != r1_y4) || (yq[1:0] == 2'b00));

        r3_ys   <= r2_a - YS_W'(r2_q100) + YS_W'(r2_q100[Q4_W-1:2]);
        r3_leap <= r2_leap;
    end

    assign o_ys   = r3_ys;
    assign o_leap = r3_leap;

endmodule

>>> rtl/cda_seq.sv
// Microcode sequencer: step counter, control-word ROM and conditional jumps.
// Depends on cda_pkg.
module cda_seq
    import cda_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req,
    input  logic      i_out_free,
    input  t_flags    i_flags,
    output t_uword    o_uw,
    output t_seq_stat o_stat
);

    localparam logic [PC_W-1:0] PC_IDLE  = 6'd0;
    localparam logic [PC_W-1:0] PC_ML1   = 6'd7;
    localparam logic [PC_W-1:0] PC_SHIFT = 6'd9;
    localparam logic [PC_W-1:0] PC_L1    = 6'd18;
    localparam logic [PC_W-1:0] PC_L2    = 6'd23;
    localparam logic [PC_W-1:0] PC_ML2   = 6'd33;
    localparam logic [PC_W-1:0] PC_DIFF  = 6'd35;
    localparam logic [PC_W-1:0] PC_ML3   = 6'd40;
    localparam logic [PC_W-1:0] PC_ABSD  = 6'd42;
    localparam logic [PC_W-1:0] PC_EMIT  = 6'd44;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '0;
        case (pc)
            PC_IDLE: begin
                w.cond = C_NO_REQ; w.target = PC_IDLE;
            end
            6'd1: begin
                w.cond = C_IS_CMP; w.target = PC_EMIT;
            end
            // serial of the first date
            6'd2: begin
                w.year_op = Y_LDSEL; w.mk_op = K_ONE; w.acc_op = A_LDDAY;
                w.err_op = E_CHKY;
            end
            6'd3, 6'd4, 6'd5: begin
            end
            6'd6: begin
                w.acc_op = A_ADDYS;
            end
            PC_ML1: begin
                w.cond = C_MK_GE_M; w.target = PC_SHIFT;
            end
            6'd8: begin
                w.acc_op = A_ADDML; w.mk_op = K_INC;
                w.cond = C_ALWAYS; w.target = PC_ML1;
            end
            PC_SHIFT: begin
                w.cond = C_IS_DIFF; w.target = PC_DIFF;
            end
            6'd10: begin
                w.cond = C_ERR; w.target = PC_EMIT;
            end
            6'd11: begin
                w.acc_op = A_ADDOFF;
            end
            6'd12: begin
                w.err_op = E_CHKT;
            end
            6'd13: begin
                w.cond = C_ERR; w.target = PC_EMIT;
            end
            // year search from the estimate
            6'd14: begin
                w.year_op = Y_LDEST;
            end
            6'd15, 6'd16, 6'd17: begin
            end
            PC_L1: begin
                w.cond = C_L1_EXIT; w.target = PC_L2;
            end
            6'd19: begin
                w.year_op = Y_DEC;
            end
            6'd20, 6'd21: begin
            end
            6'd22: begin
                w.cond = C_ALWAYS; w.target = PC_L1;
            end
            PC_L2: begin
                w.year_op = Y_INC;
            end
            6'd24, 6'd25, 6'd26: begin
            end
            6'd27: begin
                w.cond = C_YS_LE_S; w.target = PC_L2;
            end
            6'd28: begin
                w.year_op = Y_DEC;
            end
            6'd29, 6'd30, 6'd31: begin
            end
            6'd32: begin
                w.acc_op = A_SUBYS; w.mk_op = K_ONE;
            end
            PC_ML2: begin
                w.cond = C_MDONE; w.target = PC_EMIT;
            end
            6'd34: begin
                w.acc_op = A_SUBML; w.mk_op = K_INC;
                w.cond = C_ALWAYS; w.target = PC_ML2;
            end
            // serial of the second date, then the distance
            PC_DIFF: begin
                w.save_tmp = 1'b1; w.sel = 1'b1; w.year_op = Y_LDSEL;
                w.mk_op = K_ONE; w.acc_op = A_LDDAY;
            end
            6'd36, 6'd37, 6'd38: begin
            end
            6'd39: begin
                w.acc_op = A_ADDYS;
            end
            PC_ML3: begin
                w.sel = 1'b1; w.cond = C_MK_GE_M; w.target = PC_ABSD;
            end
            6'd41: begin
                w.acc_op = A_ADDML; w.mk_op = K_INC;
                w.cond = C_ALWAYS; w.target = PC_ML3;
            end
            PC_ABSD: begin
                w.acc_op = A_SUBT;
            end
            6'd43: begin
                w.acc_op = A_ABS;
            end
            PC_EMIT: begin
                w.emit = 1'b1; w.cond = C_OUT_BUSY; w.target = PC_EMIT;
            end
            default: begin
                w.cond = C_ALWAYS; w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          uw;
    logic            take;

    assign uw = ucode(r_pc);

    always_comb begin
        case (uw.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_REQ:   take = !i_req;
            C_OUT_BUSY: take = !i_out_free;
            C_IS_CMP:   take = i_flags.is_cmp;
            C_IS_DIFF:  take = i_flags.is_diff;
            C_ERR:      take = i_flags.err;
            C_MK_GE_M:  take = i_flags.mk_ge_m;
            C_L1_EXIT:  take = i_flags.l1_exit;
            C_YS_LE_S:  take = i_flags.ys_le_s;
            C_MDONE:    take = i_flags.mdone;
            default:    take = 1'b0;
        endcase
        n_pc = take ? uw.target : r_pc + PC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uw        = uw;
    assign o_stat.idle = (r_pc == PC_IDLE);
    assign o_stat.emit = uw.emit;

endmodule

>>> rtl/cda_dpath.sv
// Datapath: request latch, serial accumulator, year and month registers, result mux.
// Depends on cda_pkg and cda_ys_unit.
module cda_dpath
    import cda_pkg::*;
#(
    parameter int unsigned YEAR_MAX = CDA_YEAR_MAX
)
(
    input  logic   i_clk,
    input  logic   i_load,
    input  t_req   i_req,
    input  t_uword i_uw,
    output t_flags o_flags,
    output t_res   o_res
);

    localparam int PROD_W = EST_IN_W + RECIP_Y_W;
    localparam logic [YEAR_W-1:0] YMAX_V = YEAR_W'(YEAR_MAX);
    localparam logic signed [SERIAL_W-1:0] SMAX_V =
        SERIAL_W'(cda_year_start(int'(YEAR_MAX) + 1));
    localparam logic signed [SERIAL_W-1:0] CNT_MAX_V = SERIAL_W'(CNT_MAX);

    t_req                        r_req;
    logic [YEAR_W-1:0]           r_year, n_year;
    logic [MONTH_W-1:0]          r_mk, n_mk;
    logic signed [SERIAL_W-1:0]  r_acc, n_acc;
    logic signed [SERIAL_W-1:0]  r_tmp;
    logic                        r_err, n_err;
    logic [PROD_W-1:0]           r_prod;

    logic [YS_W-1:0]             ys;
    logic                        leap;
    logic [IN_YEAR_W-1:0]        sel_y;
    logic [MONTH_W-1:0]          sel_m;
    logic [DAY_W-1:0]            sel_d;
    logic [MONTH_W-1:0]          fix_m;
    logic [DAY_W-1:0]            mlen;
    logic signed [SERIAL_W-1:0]  ys_s, mlen_s, off_s, day_s;
    logic                        later;
    logic [ORD_W-1:0]            order;

    cda_ys_unit u_ys (
        .i_clk  (i_clk),
        .i_year (r_year),
        .o_ys   (ys),
        .o_leap (leap)
    );

    assign sel_y  = i_uw.sel ? r_req.y2 : r_req.y1;
    assign sel_m  = i_uw.sel ? r_req.m2 : r_req.m1;
    assign sel_d  = i_uw.sel ? r_req.d2 : r_req.d1;
    assign fix_m  = cda_fix_month(sel_m);
    assign mlen   = cda_month_len(leap, r_mk);
    assign ys_s   = {{(SERIAL_W-YS_W){1'b0}}, ys};
    assign mlen_s = {{(SERIAL_W-DAY_W){1'b0}}, mlen};
    assign off_s  = {{(SERIAL_W-OFF_W){r_req.off[OFF_W-1]}}, r_req.off};
    assign day_s  = {{(SERIAL_W-DAY_W){1'b0}}, sel_d};

    always_comb begin
        case (i_uw.acc_op)
            A_LDDAY:  n_acc = day_s - SERIAL_W'(1);
            A_ADDYS:  n_acc = r_acc + ys_s;
            A_SUBYS:  n_acc = r_acc - ys_s;
            A_ADDML:  n_acc = r_acc + mlen_s;
            A_SUBML:  n_acc = r_acc - mlen_s;
            A_ADDOFF: n_acc = (r_req.op == OP_SUB) ? r_acc - off_s : r_acc + off_s;
            A_SUBT:   n_acc = r_tmp - r_acc;
            A_ABS:    n_acc = (r_acc < 0) ? -r_acc : r_acc;
            default:  n_acc = r_acc;
        endcase

        case (i_uw.year_op)
            Y_LDSEL: n_year = (sel_y == '0) ? YEAR_W'(1) : YEAR_W'(sel_y);
            Y_LDEST: n_year = YEAR_W'(r_prod[PROD_W-1:RECIP_Y_SHIFT]) + YEAR_W'(1);
            Y_INC:   n_year = r_year + YEAR_W'(1);
            Y_DEC:   n_year = r_year - YEAR_W'(1);
            default: n_year = r_year;
        endcase

        case (i_uw.mk_op)
            K_ONE:   n_mk = MONTH_W'(1);
            K_INC:   n_mk = r_mk + MONTH_W'(1);
            default: n_mk = r_mk;
        endcase

        case (i_uw.err_op)
            E_CHKY:  n_err = (r_req.y1 == '0) || (YEAR_W'(r_req.y1) > YMAX_V);
            E_CHKT:  n_err = (r_acc < 0) || (r_acc >= SMAX_V);
            default: n_err = r_err;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_req <= i_req;
        end
        if (i_uw.save_tmp) begin
            r_tmp <= r_acc;
        end
        r_acc  <= n_acc;
        r_year <= n_year;
        r_mk   <= n_mk;
        r_err  <= n_err;
        r_prod <= PROD_W'(r_acc[EST_IN_W-1:0]) * PROD_W'(RECIP_YEAR);
    end

    assign o_flags.mk_ge_m = (r_mk >= fix_m);
    assign o_flags.is_cmp  = (r_req.op == OP_CMP);
    assign o_flags.is_diff = (r_req.op == OP_DIFF);
    assign o_flags.err     = r_err;
    assign o_flags.l1_exit = (ys_s <= r_acc) || (r_year < YEAR_W'(2));
    assign o_flags.ys_le_s = (ys_s <= r_acc);
    assign o_flags.mdone   = (r_mk == MONTHS) || (r_acc < mlen_s);

    assign later = (r_req.y1 > r_req.y2) ||
                   ((r_req.y1 == r_req.y2) && (r_req.m1 > r_req.m2)) ||
                   ((r_req.y1 == r_req.y2) && (r_req.m1 == r_req.m2) &&
                    (r_req.d1 > r_req.d2));

    always_comb begin
        if ((r_req.y1 == r_req.y2) && (r_req.m1 == r_req.m2) && (r_req.d1 == r_req.d2)) begin
            order = ORD_EQUAL;
        end else if (later) begin
            order = ORD_LATER;
        end else begin
            order = ORD_EARLIER;
        end
    end

    always_comb begin
        o_res = '0;
        case (r_req.op)
            OP_ADD, OP_SUB: begin
                o_res.err = r_err;
                if (r_err) begin
                    o_res.year  = r_req.y1;
                    o_res.month = r_req.m1;
                    o_res.day   = r_req.d1;
                end else begin
                    o_res.year  = r_year[IN_YEAR_W-1:0];
                    o_res.month = r_mk;
                    o_res.day   = r_acc[DAY_W-1:0] + DAY_W'(1);
                end
            end
            OP_CMP: begin
                o_res.order = order;
            end
            OP_DIFF: begin
                o_res.count = (r_acc > CNT_MAX_V) ? CNT_MAX : r_acc[CNT_W-1:0];
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

>>> rtl/calendar_date_arithmetic.sv
// Gregorian date add/subtract/compare/difference, microcoded, one request at a time.
// Depends on cda_pkg, cda_seq, cda_dpath and the assertion macro header.
// Compare goes straight to the result; difference walks the months of both dates;
// add/subtract walks months and searches the year, ending early when out of range;
// year-search steps go through the 3-stage year-start pipeline.
// Reset clears the step counter and the output valid; no clearing pass.
`include "calendar_date_arithmetic_macros.svh"
module calendar_date_arithmetic
    import cda_pkg::*;
#(
    parameter int unsigned YEAR_MAX = CDA_YEAR_MAX
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // first_year, first_month, first_day, second_year, second_month, second_day,
    // day_offset, zero pad
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // operation
    input  logic [OP_W-1:0]      i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // result_year, result_month, result_day, order, day_count, range_error
    output logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    t_req      req;
    t_uword    uw;
    t_flags    flags;
    t_seq_stat stat;
    t_res      res;
    logic      accept;
    logic      out_free;
    logic      emit_fire;

    logic                 r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;

    assign req.op  = i_s_axis_tuser;
    assign req.y1  = i_s_axis_tdata[13:0];
    assign req.m1  = i_s_axis_tdata[17:14];
    assign req.d1  = i_s_axis_tdata[22:18];
    assign req.y2  = i_s_axis_tdata[36:23];
    assign req.m2  = i_s_axis_tdata[40:37];
    assign req.d2  = i_s_axis_tdata[45:41];
    assign req.off = i_s_axis_tdata[66:46];

    assign o_s_axis_tready = stat.idle;
    assign accept          = i_s_axis_tvalid && stat.idle;
    assign out_free        = !r_m_tvalid || i_m_axis_tready;
    assign emit_fire       = stat.emit && out_free;

    cda_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (accept),
        .i_out_free (out_free),
        .i_flags    (flags),
        .o_uw       (uw),
        .o_stat     (stat)
    );

    cda_dpath #(
        .YEAR_MAX (YEAR_MAX)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_req   (req),
        .i_uw    (uw),
        .o_flags (flags),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (emit_fire) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_m_tdata <= {res.err, res.count, res.order, res.day, res.month, res.year};
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;

    `CDA_ASSERT_NXT(a_busy_after_req, i_s_axis_tvalid && o_s_axis_tready,
        !o_s_axis_tready, "ready held after request")
    `CDA_ASSERT_IMP(a_err_shift_only, o_m_axis_tvalid && o_m_axis_tdata[47],
        o_m_axis_tdata[46:23] == '0, "range flag with order or count")
    `CDA_ASSERT_IMP(a_count_no_date, o_m_axis_tvalid && (o_m_axis_tdata[46:25] != '0),
        (o_m_axis_tdata[24:0] == '0) && !o_m_axis_tdata[47], "count with date fields")

endmodule
